/* hdl/v4ft_pkg.sv */
// Shared constants and types for the IPv4 five-tuple header parser.
`timescale 1ns / 1ps
`default_nettype none

package v4ft_pkg;

  localparam int unsigned DEF_LENGTH_WIDTH = 16;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Minimum frame lengths for a counted frame and complete L4 headers
  localparam logic [31:0] MIN_IPV4_LEN = 32'd34;
  localparam logic [31:0] MIN_UDP_LEN  = 32'd42;
  localparam logic [31:0] MIN_TCP_LEN  = 32'd54;

  // Byte offsets of captured header fields
  localparam logic [31:0] OFF_ETH_FIRST   = 32'd12;
  localparam logic [31:0] OFF_ETH_LAST    = 32'd13;
  localparam logic [31:0] OFF_PROTO       = 32'd23;
  localparam logic [31:0] OFF_SADDR_FIRST = 32'd26;
  localparam logic [31:0] OFF_SADDR_LAST  = 32'd29;
  localparam logic [31:0] OFF_DADDR_FIRST = 32'd30;
  localparam logic [31:0] OFF_DADDR_LAST  = 32'd33;
  localparam logic [31:0] OFF_SPORT_FIRST = 32'd34;
  localparam logic [31:0] OFF_SPORT_LAST  = 32'd35;
  localparam logic [31:0] OFF_DPORT_FIRST = 32'd36;
  localparam logic [31:0] OFF_DPORT_LAST  = 32'd37;

  localparam logic [1:0] ST_DROP   = 2'd0;
  localparam logic [1:0] ST_TRUNC  = 2'd1;
  localparam logic [1:0] ST_RECORD = 2'd2;

  // One finished frame, handed from the capture stage to the result stage
  typedef struct packed {
    logic [15:0] ethertype;
    logic [7:0]  protocol;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  queue;
    logic [63:0] stamp;
    logic [15:0] frame_length;
    logic [63:0] byte_addend;
    logic        ge_ipv4;
    logic        ge_udp;
    logic        ge_tcp;
  } v4ft_summary_t;

endpackage

`default_nettype wire

/* hdl/ipv4_five_tuple_header_parser_core.sv */
// out_valid rises when the last byte's frame summary enters the result register.
// Throughput: one frame byte per cycle while in_stall is low; the status compares and
// one 64-bit add per total sit between the summary register and the result register.
// in_stall rises only while a finished frame summary waits on a stalled result.
// Reset (synchronous, rst_n low) clears the offset, captured fields and totals.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_five_tuple_header_parser_core
  import v4ft_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_packet_byte,
  input  wire logic        in_last_byte,
  input  wire logic [7:0]  in_queue_index,
  input  wire logic [63:0] in_now_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [63:0]      out_record_time,
  output logic [15:0]      out_frame_length,
  output logic [7:0]       out_rx_queue,
  output logic [31:0]      out_source_address,
  output logic [31:0]      out_target_address,
  output logic [15:0]      out_src_port,
  output logic [15:0]      out_target_port,
  output logic [7:0]       out_ip_protocol,
  output logic [63:0]      out_packets_total,
  output logic [63:0]      out_bytes_total
);

  logic          sum_valid;
  logic          sum_take;
  v4ft_summary_t sum;

  v4ft_capture #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_capture (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_packet_byte (in_packet_byte),
    .in_last_byte   (in_last_byte),
    .in_queue_index (in_queue_index),
    .in_now_time    (in_now_time),
    .sum_valid      (sum_valid),
    .sum            (sum),
    .sum_take       (sum_take)
  );

  v4ft_result u_result (
    .clk                (clk),
    .rst_n              (rst_n),
    .sum_valid          (sum_valid),
    .sum                (sum),
    .sum_take           (sum_take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_record_time    (out_record_time),
    .out_frame_length   (out_frame_length),
    .out_rx_queue       (out_rx_queue),
    .out_source_address (out_source_address),
    .out_target_address (out_target_address),
    .out_src_port       (out_src_port),
    .out_target_port    (out_target_port),
    .out_ip_protocol    (out_ip_protocol),
    .out_packets_total  (out_packets_total),
    .out_bytes_total    (out_bytes_total)
  );

endmodule

`default_nettype wire

/* hdl/v4ft_capture.sv */
// Byte offset counter and header field capture; registers one summary per frame.
`timescale 1ns / 1ps
`default_nettype none

module v4ft_capture
  import v4ft_pkg::*;
#(
  parameter int unsigned LENGTH_WIDTH = DEF_LENGTH_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_packet_byte,
  input  wire logic          in_last_byte,
  input  wire logic [7:0]    in_queue_index,
  input  wire logic [63:0]   in_now_time,
  output logic               sum_valid,
  output v4ft_summary_t      sum,
  input  wire logic          sum_take
);

  logic [LENGTH_WIDTH-1:0] offset_r, offset_nxt;
  logic [LENGTH_WIDTH-1:0] len;
  logic [31:0]             off32;
  logic [31:0]             len32;
  logic [15:0]             eth_r, eth_nxt;
  logic [7:0]              proto_r, proto_nxt;
  logic [31:0]             saddr_r, saddr_nxt;
  logic [31:0]             daddr_r, daddr_nxt;
  logic [15:0]             sport_r, sport_nxt;
  logic [15:0]             dport_r, dport_nxt;
  logic                    sum_valid_r, sum_valid_nxt;
  v4ft_summary_t           sum_r, sum_nxt;
  logic                    accept;

  assign in_stall  = sum_valid_r && !sum_take;
  assign accept    = in_valid && !in_stall;
  assign sum_valid = sum_valid_r;
  assign sum       = sum_r;

  assign off32 = 32'(offset_r);
  assign len   = (offset_r == {LENGTH_WIDTH{1'b1}}) ? offset_r
                                                    : offset_r + 1'b1;
  assign len32 = 32'(len);

  // Fields including the current byte
  always_comb begin
    eth_nxt   = eth_r;
    proto_nxt = proto_r;
    saddr_nxt = saddr_r;
    daddr_nxt = daddr_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    if (off32 == OFF_ETH_FIRST || off32 == OFF_ETH_LAST) begin
      eth_nxt = {eth_r[7:0], in_packet_byte};
    end
    if (off32 == OFF_PROTO) begin
      proto_nxt = in_packet_byte;
    end
    if (off32 >= OFF_SADDR_FIRST && off32 <= OFF_SADDR_LAST) begin
      saddr_nxt = {saddr_r[23:0], in_packet_byte};
    end
    if (off32 >= OFF_DADDR_FIRST && off32 <= OFF_DADDR_LAST) begin
      daddr_nxt = {daddr_r[23:0], in_packet_byte};
    end
    if (off32 == OFF_SPORT_FIRST || off32 == OFF_SPORT_LAST) begin
      sport_nxt = {sport_r[7:0], in_packet_byte};
    end
    if (off32 == OFF_DPORT_FIRST || off32 == OFF_DPORT_LAST) begin
      dport_nxt = {dport_r[7:0], in_packet_byte};
    end
  end

  assign offset_nxt = in_last_byte ? '0 : len;

  always_comb begin
    sum_nxt.ethertype    = eth_nxt;
    sum_nxt.protocol     = proto_nxt;
    sum_nxt.saddr        = saddr_nxt;
    sum_nxt.daddr        = daddr_nxt;
    sum_nxt.sport        = sport_nxt;
    sum_nxt.dport        = dport_nxt;
    sum_nxt.queue        = in_queue_index;
    sum_nxt.stamp        = in_now_time;
    sum_nxt.frame_length = 16'(len);
    sum_nxt.byte_addend  = 64'(len);
    sum_nxt.ge_ipv4      = len32 >= MIN_IPV4_LEN;
    sum_nxt.ge_udp       = len32 >= MIN_UDP_LEN;
    sum_nxt.ge_tcp       = len32 >= MIN_TCP_LEN;
  end

  always_comb begin
    sum_valid_nxt = sum_valid_r;
    if (sum_take) begin
      sum_valid_nxt = 1'b0;
    end
    if (accept && in_last_byte) begin
      sum_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      eth_r       <= '0;
      proto_r     <= '0;
      saddr_r     <= '0;
      daddr_r     <= '0;
      sport_r     <= '0;
      dport_r     <= '0;
      sum_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= sum_valid_nxt;
      if (accept) begin
        offset_r <= offset_nxt;
        if (in_last_byte) begin
          eth_r   <= '0;
          proto_r <= '0;
          saddr_r <= '0;
          daddr_r <= '0;
          sport_r <= '0;
          dport_r <= '0;
        end else begin
          eth_r   <= eth_nxt;
          proto_r <= proto_nxt;
          saddr_r <= saddr_nxt;
          daddr_r <= daddr_nxt;
          sport_r <= sport_nxt;
          dport_r <= dport_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_byte) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/v4ft_result.sv */
// Frame classification, running totals and the result register.
`timescale 1ns / 1ps
`default_nettype none

module v4ft_result
  import v4ft_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          sum_valid,
  input  wire v4ft_summary_t sum,
  output logic               sum_take,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_status,
  output logic [63:0]        out_record_time,
  output logic [15:0]        out_frame_length,
  output logic [7:0]         out_rx_queue,
  output logic [31:0]        out_source_address,
  output logic [31:0]        out_target_address,
  output logic [15:0]        out_src_port,
  output logic [15:0]        out_target_port,
  output logic [7:0]         out_ip_protocol,
  output logic [63:0]        out_packets_total,
  output logic [63:0]        out_bytes_total
);

  logic        out_valid_r;
  logic [63:0] pkt_r, pkt_nxt;
  logic [63:0] bytes_r, bytes_nxt;
  logic        counted;
  logic        is_udp;
  logic        is_tcp;
  logic [1:0]  status_nxt;
  logic        rec;

  logic [1:0]  status_r;
  logic [63:0] time_r;
  logic [15:0] flen_r;
  logic [7:0]  queue_r;
  logic [31:0] saddr_r;
  logic [31:0] daddr_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [7:0]  proto_r;

  assign sum_take = sum_valid && (!out_valid_r || !out_stall);

  assign is_udp  = sum.protocol == PROTO_UDP;
  assign is_tcp  = sum.protocol == PROTO_TCP;
  assign counted = sum.ge_ipv4 && (sum.ethertype == ETHERTYPE_IPV4);

  always_comb begin
    status_nxt = ST_DROP;
    if (counted) begin
      status_nxt = ST_RECORD;
      if ((is_udp && !sum.ge_udp) || (is_tcp && !sum.ge_tcp)) begin
        status_nxt = ST_TRUNC;
      end
    end
  end

  assign rec       = status_nxt == ST_RECORD;
  assign pkt_nxt   = counted ? pkt_r + 64'd1 : pkt_r;
  assign bytes_nxt = counted ? bytes_r + sum.byte_addend : bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pkt_r       <= '0;
      bytes_r     <= '0;
    end else begin
      if (sum_take) begin
        out_valid_r <= 1'b1;
        pkt_r       <= pkt_nxt;
        bytes_r     <= bytes_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Record fields read as zero unless the record is valid
  always_ff @(posedge clk) begin
    if (sum_take) begin
      status_r <= status_nxt;
      time_r   <= rec ? sum.stamp : '0;
      flen_r   <= rec ? sum.frame_length : '0;
      queue_r  <= rec ? sum.queue : '0;
      saddr_r  <= rec ? sum.saddr : '0;
      daddr_r  <= rec ? sum.daddr : '0;
      sport_r  <= (rec && (is_udp || is_tcp)) ? sum.sport : '0;
      dport_r  <= (rec && (is_udp || is_tcp)) ? sum.dport : '0;
      proto_r  <= rec ? sum.protocol : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_record_time    = time_r;
  assign out_frame_length   = flen_r;
  assign out_rx_queue       = queue_r;
  assign out_source_address = saddr_r;
  assign out_target_address = daddr_r;
  assign out_src_port       = sport_r;
  assign out_target_port    = dport_r;
  assign out_ip_protocol    = proto_r;
  assign out_packets_total  = pkt_r;
  assign out_bytes_total    = bytes_r;

endmodule

`default_nettype wire

/* hdl/v4ft_checker.sv */
// Port-level assertions for the parser core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module v4ft_checker
  import v4ft_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [63:0] out_record_time,
  input wire logic [15:0] out_frame_length,
  input wire logic [7:0]  out_rx_queue,
  input wire logic [31:0] out_source_address,
  input wire logic [31:0] out_target_address,
  input wire logic [15:0] out_src_port,
  input wire logic [15:0] out_target_port,
  input wire logic [7:0]  out_ip_protocol,
  input wire logic [63:0] out_packets_total,
  input wire logic [63:0] out_bytes_total
);

  // A stalled request keeps its totals
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_packets_total)
      && $stable(out_bytes_total) && $stable(out_status))
    else $error("stalled result request changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DROP || out_status == ST_TRUNC
      || out_status == ST_RECORD))
    else $error("undefined status code");

  a_no_record_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_RECORD |-> out_record_time == 64'd0
      && out_frame_length == 16'd0 && out_rx_queue == 8'd0
      && out_source_address == 32'd0 && out_target_address == 32'd0
      && out_src_port == 16'd0 && out_target_port == 16'd0
      && out_ip_protocol == 8'd0)
    else $error("record fields set without a valid record");

  a_ports_l4_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ip_protocol != PROTO_TCP && out_ip_protocol != PROTO_UDP
      |-> out_src_port == 16'd0 && out_target_port == 16'd0)
    else $error("ports reported for a non-TCP/UDP protocol");

endmodule

bind ipv4_five_tuple_header_parser_core v4ft_checker u_v4ft_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_record_time    (out_record_time),
  .out_frame_length   (out_frame_length),
  .out_rx_queue       (out_rx_queue),
  .out_source_address (out_source_address),
  .out_target_address (out_target_address),
  .out_src_port       (out_src_port),
  .out_target_port    (out_target_port),
  .out_ip_protocol    (out_ip_protocol),
  .out_packets_total  (out_packets_total),
  .out_bytes_total    (out_bytes_total)
);

`default_nettype wire

/* test/ipv4_five_tuple_header_parser_core_tb.sv */
// Self-checking testbench for the IPv4 five-tuple header parser core.
`timescale 1ns / 1ps

module ipv4_five_tuple_header_parser_core_tb;
  import v4ft_pkg::*;

  localparam int unsigned LEN_BITS = DEF_LENGTH_WIDTH;

  // Codes used by the stimulus only
  localparam logic [7:0]  PROTO_ICMP = 8'd1;
  localparam logic [15:0] ETH_ARP    = 16'h0806;
  localparam logic [15:0] ETH_IPV6   = 16'h86DD;
  localparam logic [15:0] ETH_VLAN   = 16'h8100;

  localparam int unsigned TOTAL_BYTES = 1600;
  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] stamp;
    logic [15:0] length;
    logic [7:0]  queue;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  proto;
    logic [63:0] pkts;
    logic [63:0] octets;
  } flow_rec_t;

  // One frame to send; the exp_ columns are used only when typed is set
  typedef struct {
    int unsigned len;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  queue;
    logic [63:0] stamp;
    bit          typed;
    logic [1:0]  exp_status;
    logic [15:0] exp_len;
    logic [63:0] exp_pkts;
    logic [63:0] exp_octets;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_packet_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [7:0]  in_queue_index = '0;
  logic [63:0] in_now_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_record_time;
  logic [15:0] out_frame_length;
  logic [7:0]  out_rx_queue;
  logic [31:0] out_source_address;
  logic [31:0] out_target_address;
  logic [15:0] out_src_port;
  logic [15:0] out_target_port;
  logic [7:0]  out_ip_protocol;
  logic [63:0] out_packets_total;
  logic [63:0] out_bytes_total;

  ipv4_five_tuple_header_parser_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_packet_byte     (in_packet_byte),
    .in_last_byte       (in_last_byte),
    .in_queue_index     (in_queue_index),
    .in_now_time        (in_now_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_record_time    (out_record_time),
    .out_frame_length   (out_frame_length),
    .out_rx_queue       (out_rx_queue),
    .out_source_address (out_source_address),
    .out_target_address (out_target_address),
    .out_src_port       (out_src_port),
    .out_target_port    (out_target_port),
    .out_ip_protocol    (out_ip_protocol),
    .out_packets_total  (out_packets_total),
    .out_bytes_total    (out_bytes_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser state mirrored by the predictor
  logic [LEN_BITS-1:0] frame_offset = '0;
  logic [15:0] seen_etype = '0;
  logic [7:0]  seen_proto = '0;
  logic [31:0] seen_saddr = '0;
  logic [31:0] seen_daddr = '0;
  logic [15:0] seen_sport = '0;
  logic [15:0] seen_dport = '0;
  logic [63:0] pkt_total = '0;
  logic [63:0] octet_total = '0;

  flow_rec_t   pending_records[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned records_checked = 0;
  int unsigned status_seen[3] = '{0, 0, 0};
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;
  int unsigned hold_left = 0;

  frame_row_t directed_rows [0:20] = '{
    '{1, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0, 8'h00, 64'h0,
      1'b1, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{33, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0002, 16'h1234, 16'h0035,
      8'h01, 64'h10, 1'b1, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{34, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0002, 16'h1234, 16'h0035,
      8'h02, 64'h20, 1'b1, ST_TRUNC, 16'd0, 64'd1, 64'd34},
    '{41, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0002, 16'h1234, 16'h0035,
      8'h02, 64'h30, 1'b1, ST_TRUNC, 16'd0, 64'd2, 64'd75},
    '{42, ETHERTYPE_IPV4, PROTO_UDP, 32'hC0A8_0001, 32'h0A00_0002, 16'h1234, 16'h0035,
      8'h03, 64'h1, 1'b1, ST_RECORD, 16'd42, 64'd3, 64'd117},
    '{53, ETHERTYPE_IPV4, PROTO_TCP, 32'hAC10_0005, 32'h0808_0808, 16'h0050, 16'hC350,
      8'h04, 64'h40, 1'b1, ST_TRUNC, 16'd0, 64'd4, 64'd170},
    '{54, ETHERTYPE_IPV4, PROTO_TCP, 32'hAC10_0005, 32'h0808_0808, 16'h0050, 16'hC350,
      8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_RECORD, 16'd54, 64'd5, 64'd224},
    '{34, ETHERTYPE_IPV4, PROTO_ICMP, 32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'hBEEF, 16'hCAFE,
      8'h07, 64'h0123_4567_89AB_CDEF, 1'b1, ST_RECORD, 16'd34, 64'd6, 64'd258},
    '{60, ETH_IPV6, PROTO_TCP, 32'h0102_0304, 32'h0506_0708, 16'h0001, 16'h0002,
      8'h08, 64'h50, 1'b1, ST_DROP, 16'd0, 64'd6, 64'd258},
    '{60, ETH_ARP, PROTO_UDP, 32'h0102_0304, 32'h0506_0708, 16'h0001, 16'h0002,
      8'h09, 64'h60, 1'b1, ST_DROP, 16'd0, 64'd6, 64'd258},
    '{28, ETHERTYPE_IPV4, PROTO_UDP, 32'h0102_0304, 32'h0506_0708, 16'h0001, 16'h0002,
      8'h0A, 64'h70, 1'b1, ST_DROP, 16'd0, 64'd6, 64'd258},
    // From here on the predictor supplies the expectation
    '{255, ETHERTYPE_IPV4, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
      8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{38, 16'hFFFF, PROTO_UDP, 32'h1, 32'h2, 16'h3, 16'h4,
      8'h11, 64'h80, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{34, 16'h0000, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0,
      8'h00, 64'h0, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{34, ETHERTYPE_IPV4, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0,
      8'h00, 64'h0, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{54, ETHERTYPE_IPV4, PROTO_TCP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
      8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{42, ETHERTYPE_IPV4, PROTO_UDP, 32'h0, 32'h0, 16'h0, 16'h0,
      8'h00, 64'h0, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{100, ETH_VLAN, PROTO_UDP, 32'hC0A8_0101, 32'hC0A8_0102, 16'h1111, 16'h2222,
      8'h33, 64'h90, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{70, ETHERTYPE_IPV4, PROTO_UDP, 32'h8000_0001, 32'h7FFF_FFFE, 16'h8001, 16'h7FFE,
      8'h80, 64'h8000_0000_0000_0000, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{47, ETHERTYPE_IPV4, PROTO_TCP, 32'h5555_AAAA, 32'hAAAA_5555, 16'h5A5A, 16'hA5A5,
      8'h55, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0},
    '{64, ETHERTYPE_IPV4, PROTO_TCP, 32'h0A00_0001, 32'h0A00_00FE, 16'h01BB, 16'hD431,
      8'h12, 64'hA0, 1'b0, ST_DROP, 16'd0, 64'd0, 64'd0}
  };

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Advances the parser by one byte; returns 1 when the byte ends a frame
  function automatic bit parse_byte(input logic [7:0] b, input bit last,
                                    input logic [7:0] q, input logic [63:0] stamp,
                                    output flow_rec_t rec);
    logic [31:0] off;
    logic [LEN_BITS-1:0] len;
    bit has_ports;
    rec = '0;
    off = 32'(frame_offset);
    if (off == OFF_ETH_FIRST || off == OFF_ETH_LAST) seen_etype = {seen_etype[7:0], b};
    else if (off == OFF_PROTO) seen_proto = b;
    else if (off >= OFF_SADDR_FIRST && off <= OFF_SADDR_LAST)
      seen_saddr = {seen_saddr[23:0], b};
    else if (off >= OFF_DADDR_FIRST && off <= OFF_DADDR_LAST)
      seen_daddr = {seen_daddr[23:0], b};
    else if (off == OFF_SPORT_FIRST || off == OFF_SPORT_LAST)
      seen_sport = {seen_sport[7:0], b};
    else if (off == OFF_DPORT_FIRST || off == OFF_DPORT_LAST)
      seen_dport = {seen_dport[7:0], b};
    // offset saturates on very long frames
    len = (frame_offset == '1) ? frame_offset : frame_offset + 1'b1;
    frame_offset = len;
    if (!last) return 1'b0;

    rec.status = ST_DROP;
    if (32'(len) >= MIN_IPV4_LEN && seen_etype == ETHERTYPE_IPV4) begin
      pkt_total += 64'd1;
      octet_total += 64'(len);
      rec.status = ST_RECORD;
      if ((seen_proto == PROTO_UDP && 32'(len) < MIN_UDP_LEN) ||
          (seen_proto == PROTO_TCP && 32'(len) < MIN_TCP_LEN))
        rec.status = ST_TRUNC;
      if (rec.status == ST_RECORD) begin
        has_ports = (seen_proto == PROTO_UDP || seen_proto == PROTO_TCP);
        rec.stamp = stamp;
        rec.length = 16'(len);
        rec.queue = q;
        rec.saddr = seen_saddr;
        rec.daddr = seen_daddr;
        rec.sport = has_ports ? seen_sport : 16'h0;
        rec.dport = has_ports ? seen_dport : 16'h0;
        rec.proto = seen_proto;
      end
    end
    rec.pkts = pkt_total;
    rec.octets = octet_total;

    frame_offset = '0;
    seen_etype = '0;
    seen_proto = '0;
    seen_saddr = '0;
    seen_daddr = '0;
    seen_sport = '0;
    seen_dport = '0;
    return 1'b1;
  endfunction

  function automatic flow_rec_t typed_record(input frame_row_t row);
    flow_rec_t rec;
    rec = '0;
    rec.status = row.exp_status;
    rec.pkts = row.exp_pkts;
    rec.octets = row.exp_octets;
    if (row.exp_status == ST_RECORD) begin
      rec.stamp = row.stamp;
      rec.length = row.exp_len;
      rec.queue = row.queue;
      rec.saddr = row.saddr;
      rec.daddr = row.daddr;
      rec.proto = row.proto;
      if (row.proto == PROTO_UDP || row.proto == PROTO_TCP) begin
        rec.sport = row.sport;
        rec.dport = row.dport;
      end
    end
    return rec;
  endfunction

  function automatic logic [7:0] header_byte(input frame_row_t row, input int unsigned off);
    logic [31:0] o;
    o = off;
    if (o == OFF_ETH_FIRST) return row.etype[15:8];
    if (o == OFF_ETH_LAST) return row.etype[7:0];
    if (o == OFF_PROTO) return row.proto;
    if (o >= OFF_SADDR_FIRST && o <= OFF_SADDR_LAST)
      return row.saddr[8*(OFF_SADDR_LAST - o) +: 8];
    if (o >= OFF_DADDR_FIRST && o <= OFF_DADDR_LAST)
      return row.daddr[8*(OFF_DADDR_LAST - o) +: 8];
    if (o == OFF_SPORT_FIRST) return row.sport[15:8];
    if (o == OFF_SPORT_LAST) return row.sport[7:0];
    if (o == OFF_DPORT_FIRST) return row.dport[15:8];
    if (o == OFF_DPORT_LAST) return row.dport[7:0];
    return 8'($urandom);
  endfunction

  function automatic frame_row_t random_frame();
    frame_row_t row;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) row.len = $urandom_range(1, 33);
    else if (pick < 16) row.len = $urandom_range(34, 41);
    else if (pick < 32) row.len = $urandom_range(42, 53);
    else if (pick < 97) row.len = $urandom_range(54, 96);
    else row.len = $urandom_range(97, 200);
    row.etype = ($urandom_range(0, 99) < 85) ? ETHERTYPE_IPV4 : 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) row.proto = PROTO_UDP;
    else if (pick < 80) row.proto = PROTO_TCP;
    else row.proto = 8'($urandom);
    row.saddr = $urandom;
    row.daddr = $urandom;
    row.sport = 16'($urandom);
    row.dport = 16'($urandom);
    row.queue = 8'($urandom);
    row.stamp = {$urandom, $urandom};
    row.typed = 1'b0;
    row.exp_status = ST_DROP;
    row.exp_len = '0;
    row.exp_pkts = '0;
    row.exp_octets = '0;
    return row;
  endfunction

  // Drives one byte request and returns at the edge that accepts it
  task automatic push_byte(input logic [7:0] b, input bit last, input logic [7:0] q,
                           input logic [63:0] stamp);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packet_byte <= b;
    in_last_byte <= last;
    in_queue_index <= q;
    in_now_time <= stamp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input frame_row_t row);
    flow_rec_t  rec;
    logic [7:0] b;
    logic [7:0] q;
    logic [63:0] stamp;
    bit last;
    // long frames go back to back to keep the run short
    in_burst = (row.len > 1000) || ($urandom_range(0, 3) == 0);
    for (int unsigned off = 0; off < row.len; off++) begin
      last = (off == row.len - 1);
      b = header_byte(row, off);
      q = last ? row.queue : 8'($urandom);
      stamp = last ? row.stamp : {$urandom, $urandom};
      push_byte(b, last, q, stamp);
      bytes_sent++;
      if (parse_byte(b, last, q, stamp, rec))
        pending_records.push_back(row.typed ? typed_record(row) : rec);
    end
    frames_sent++;
  endtask

  task automatic check_record();
    flow_rec_t want;
    if (pending_records.size() == 0) begin
      report_mismatch("result with nothing pending, status", 64'(out_status), 64'h0);
      return;
    end
    want = pending_records.pop_front();
    records_checked++;
    if (out_status < 2'd3) status_seen[out_status]++;
    if (out_status !== want.status) report_mismatch("status", 64'(out_status), 64'(want.status));
    if (out_record_time !== want.stamp) report_mismatch("record_time", out_record_time, want.stamp);
    if (out_frame_length !== want.length)
      report_mismatch("frame_length", 64'(out_frame_length), 64'(want.length));
    if (out_rx_queue !== want.queue) report_mismatch("rx_queue", 64'(out_rx_queue), 64'(want.queue));
    if (out_source_address !== want.saddr)
      report_mismatch("source_address", 64'(out_source_address), 64'(want.saddr));
    if (out_target_address !== want.daddr)
      report_mismatch("target_address", 64'(out_target_address), 64'(want.daddr));
    if (out_src_port !== want.sport)
      report_mismatch("src_port", 64'(out_src_port), 64'(want.sport));
    if (out_target_port !== want.dport)
      report_mismatch("target_port", 64'(out_target_port), 64'(want.dport));
    if (out_ip_protocol !== want.proto)
      report_mismatch("ip_protocol", 64'(out_ip_protocol), 64'(want.proto));
    if (out_packets_total !== want.pkts)
      report_mismatch("packets_total", out_packets_total, want.pkts);
    if (out_bytes_total !== want.octets)
      report_mismatch("bytes_total", out_bytes_total, want.octets);
  endtask

  // Result side: a fresh stall length is drawn after every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_record();
        if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
        hold_left = out_burst ? 0 : $urandom_range(0, 4);
        out_stall <= (hold_left != 0);
      end else if (out_valid && hold_left != 0) begin
        hold_left--;
        if (hold_left == 0) out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned guard;
    flow_rec_t left;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_frame(directed_rows[i]);
    while (bytes_sent < TOTAL_BYTES)
      send_frame(random_frame());
    in_valid <= 1'b0;

    guard = 0;
    while (pending_records.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    while (pending_records.size() != 0) begin
      left = pending_records.pop_front();
      report_mismatch("result never came, packets_total", 64'h0, left.pkts);
    end

    $display("Sent %0d frames (%0d bytes) of mixed length, ethertype and protocol; checked %0d results",
             frames_sent, bytes_sent, records_checked);
    $display("Outcomes: %0d dropped, %0d truncated L4, %0d full records",
             status_seen[0], status_seen[1], status_seen[2]);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Timeout: run did not finish");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
